// ----- sv/lhce_pkg.sv -----
// shared types and constants for the lamp hsv color engine
`default_nettype none

package lhce_pkg;

    // attribute write opcodes
    localparam logic [2:0] OP_ONOFF   = 3'd0;
    localparam logic [2:0] OP_LEVEL   = 3'd1;
    localparam logic [2:0] OP_HUE     = 3'd2;
    localparam logic [2:0] OP_SAT     = 3'd3;
    localparam logic [2:0] OP_ENH_HUE = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_EP     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RED   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_GREEN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BLUE  = 8'd3;

    localparam logic [15:0] OWN_EP_RST     = 16'd1;
    localparam logic [8:0]  GAIN_RED_RST   = 9'd256;
    localparam logic [8:0]  GAIN_GREEN_RST = 9'd192;
    localparam logic [8:0]  GAIN_BLUE_RST  = 9'd128;

    // lamp state reset values
    localparam logic [7:0] LEVEL_RST = 8'd254;

    // color math
    localparam int FULL_SCALE = 254;
    localparam int OUT_MAX    = 255;
    localparam logic [23:0] DENOM = 24'(FULL_SCALE * FULL_SCALE * FULL_SCALE);
    // 255 * floor(2^32 / 254^3)
    localparam logic [16:0] RECIP = 17'd66810;

    // job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [15:0] endpoint;
        logic [2:0]  opcode;
        logic [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       lit;
    } out_item_t;

    typedef struct packed {
        logic       dark;
        logic [7:0] level;
        logic [7:0] hue;
        logic [7:0] sat;
    } job_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } qstat_t;

    typedef struct packed {
        logic [8:0] red;
        logic [8:0] green;
        logic [8:0] blue;
    } gains_t;

endpackage

`default_nettype wire

// ----- sv/lhce_front.sv -----
// front end: endpoint filter, lamp state update and job issue
`default_nettype none

module lhce_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire lhce_pkg::in_item_t in_data,
    input  wire logic [15:0]       own_endpoint,
    input  wire lhce_pkg::qstat_t  qstat,
    output logic                   q_wr,
    output lhce_pkg::job_t         q_job
);

    logic       lamp_on_reg;
    logic       lamp_on_next;
    logic [7:0] level_reg;
    logic [7:0] level_next;
    logic [7:0] hue_reg;
    logic [7:0] hue_next;
    logic [7:0] sat_reg;
    logic [7:0] sat_next;

    logic        hit;
    logic [23:0] enh_scaled;
    logic [16:0] enh_rem;
    logic [7:0]  enh_hue;

    assign full = qstat.full;
    assign hit  = push && !qstat.full && (in_data.endpoint == own_endpoint);

    // value*254/65535: quotient from the high bits, one correction step
    always_comb
    begin
        enh_scaled = ({8'd0, in_data.value} << 8) - ({8'd0, in_data.value} << 1);
        enh_rem    = {1'b0, enh_scaled[15:0]} + {9'd0, enh_scaled[23:16]};
        enh_hue    = enh_scaled[23:16] + ((enh_rem >= 17'd65535) ? 8'd1 : 8'd0);
    end

    always_comb
    begin
        lamp_on_next = lamp_on_reg;
        level_next   = level_reg;
        hue_next     = hue_reg;
        sat_next     = sat_reg;
        if (hit)
        begin
            unique case (in_data.opcode)
                lhce_pkg::OP_ONOFF:   lamp_on_next = (in_data.value != 16'd0);
                lhce_pkg::OP_LEVEL:   level_next   = in_data.value[7:0];
                lhce_pkg::OP_HUE:     hue_next     = in_data.value[7:0];
                lhce_pkg::OP_SAT:     sat_next     = in_data.value[7:0];
                lhce_pkg::OP_ENH_HUE: hue_next     = enh_hue;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_on_reg <= 1'b0;
            level_reg   <= lhce_pkg::LEVEL_RST;
            hue_reg     <= 8'd0;
            sat_reg     <= 8'd0;
        end
        else
        begin
            lamp_on_reg <= lamp_on_next;
            level_reg   <= level_next;
            hue_reg     <= hue_next;
            sat_reg     <= sat_next;
        end
    end

    assign q_wr        = hit;
    assign q_job.dark  = !lamp_on_next || (level_next == 8'd0);
    assign q_job.level = level_next;
    assign q_job.hue   = hue_next;
    assign q_job.sat   = sat_next;

endmodule

`default_nettype wire

// ----- sv/lhce_fifo.sv -----
// short job queue between front end and color pipeline
`default_nettype none

module lhce_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr,
    input  wire lhce_pkg::job_t  wr_job,
    input  wire logic            rd,
    output lhce_pkg::job_t       rd_job,
    output lhce_pkg::qstat_t     stat
);

    lhce_pkg::job_t slot [lhce_pkg::QDEPTH];

    logic [lhce_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [lhce_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [lhce_pkg::QCNT_W-1:0] count_reg;
    logic                        do_wr;
    logic                        do_rd;

    assign stat.full  = (count_reg == lhce_pkg::QCNT_W'(lhce_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

    assign do_wr  = wr && !stat.full;
    assign do_rd  = rd && !stat.empty;
    assign rd_job = slot[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/lhce_back.sv -----
// color pipeline: hsv sectors, scaling divide, white balance and result slot
`default_nettype none

module lhce_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lhce_pkg::qstat_t qstat,
    input  wire lhce_pkg::job_t   q_job,
    output logic                  q_rd,
    input  wire lhce_pkg::gains_t gains,
    input  wire logic             pop,
    output logic                  empty,
    output lhce_pkg::out_item_t   out_data
);

    localparam int NLANE = 3;
    localparam int NSTG  = 6;

    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;

    localparam logic [10:0] STEP  = 11'(lhce_pkg::FULL_SCALE);
    localparam logic [10:0] SPAN  = 11'(2 * lhce_pkg::FULL_SCALE);
    localparam logic [7:0]  FS8   = 8'(lhce_pkg::FULL_SCALE);
    localparam logic [15:0] FS_SQ = 16'(lhce_pkg::FULL_SCALE * lhce_pkg::FULL_SCALE);

    logic            advance;
    logic [NSTG-1:0] vld_reg;
    logic            res_valid_reg;

    // stage 0: per-lane distance from the top of the channel
    logic [7:0]  s0_g_reg [NLANE];
    logic [7:0]  s0_level_reg;
    logic [7:0]  s0_sat_reg;
    logic        s0_dark_reg;
    // stage 1: level-free channel numerator
    logic [15:0] s1_inner_reg [NLANE];
    logic [7:0]  s1_level_reg;
    logic        s1_dark_reg;
    // stage 2: numerator scaled by level
    logic [23:0] s2_prod_reg [NLANE];
    logic        s2_dark_reg;
    // stage 3: quotient estimate
    logic [8:0]  s3_qe_reg [NLANE];
    logic [23:0] s3_prod_reg [NLANE];
    logic        s3_dark_reg;
    // stage 4: dividend and next-step limit
    logic [31:0] s4_p_reg [NLANE];
    logic [31:0] s4_lim_reg [NLANE];
    logic [8:0]  s4_qe_reg [NLANE];
    logic        s4_dark_reg;
    // stage 5: clamped channel
    logic [7:0]  s5_ch_reg [NLANE];
    logic        s5_dark_reg;

    lhce_pkg::out_item_t res_reg;

    logic [10:0] h6;
    logic [10:0] h6_base;
    logic [10:0] tm;
    logic [7:0]  f;
    logic [7:0]  xg;
    logic [2:0]  sector;
    logic [7:0]  g_c [NLANE];

    logic [15:0] inner_c [NLANE];
    logic [23:0] prod_c [NLANE];
    logic [8:0]  qe_c [NLANE];
    logic [31:0] p_c [NLANE];
    logic [31:0] lim_c [NLANE];
    logic [7:0]  ch_c [NLANE];
    logic [7:0]  bal_c [NLANE];
    logic [8:0]  gain_c [NLANE];

    assign advance = !res_valid_reg || pop;
    assign q_rd    = advance && !qstat.empty;

    // hue to sector and ramp
    always_comb
    begin
        h6 = {1'b0, q_job.hue, 2'b00} + {2'b00, q_job.hue, 1'b0};
        sector = {2'b00, (h6 >= STEP)} + {2'b00, (h6 >= 11'(2 * STEP))}
               + {2'b00, (h6 >= 11'(3 * STEP))} + {2'b00, (h6 >= 11'(4 * STEP))}
               + {2'b00, (h6 >= 11'(5 * STEP))};
        if (h6 >= 11'(3 * SPAN))
        begin
            h6_base = 11'(3 * SPAN);
        end
        else if (h6 >= 11'(2 * SPAN))
        begin
            h6_base = 11'(2 * SPAN);
        end
        else if (h6 >= SPAN)
        begin
            h6_base = SPAN;
        end
        else
        begin
            h6_base = 11'd0;
        end
        tm = h6 - h6_base;
        f  = (tm >= STEP) ? 8'(SPAN - tm) : tm[7:0];
        xg = FS8 - f;
        // lane 0 red, 1 green, 2 blue; top channel 0, ramp xg, floor 254
        unique case (sector)
            SEC_0:
            begin
                g_c[0] = 8'd0; g_c[1] = xg;   g_c[2] = FS8;
            end
            SEC_1:
            begin
                g_c[0] = xg;   g_c[1] = 8'd0; g_c[2] = FS8;
            end
            SEC_2:
            begin
                g_c[0] = FS8;  g_c[1] = 8'd0; g_c[2] = xg;
            end
            SEC_3:
            begin
                g_c[0] = FS8;  g_c[1] = xg;   g_c[2] = 8'd0;
            end
            SEC_4:
            begin
                g_c[0] = xg;   g_c[1] = FS8;  g_c[2] = 8'd0;
            end
            default:
            begin
                g_c[0] = 8'd0; g_c[1] = FS8;  g_c[2] = xg;
            end
        endcase
    end

    always_comb
    begin
        gain_c[0] = gains.red;
        gain_c[1] = gains.green;
        gain_c[2] = gains.blue;
        for (int i = 0; i < NLANE; i++)
        begin
            // 254^2 - sat*g, negative sums clamp to zero
            inner_c[i] = ((16'(s0_sat_reg) * 16'(s0_g_reg[i])) >= FS_SQ) ? 16'd0
                       : FS_SQ - 16'(s0_sat_reg) * 16'(s0_g_reg[i]);
            prod_c[i]  = 24'(s1_level_reg) * 24'(s1_inner_reg[i]);
            qe_c[i]    = 9'((41'(s2_prod_reg[i]) * 41'(lhce_pkg::RECIP)) >> 32);
            p_c[i]     = ({8'd0, s3_prod_reg[i]} << 8) - {8'd0, s3_prod_reg[i]};
            lim_c[i]   = 32'(s3_qe_reg[i] + 9'd1) * 32'(lhce_pkg::DENOM);
            if ((s4_qe_reg[i] >= 9'(lhce_pkg::OUT_MAX))
                || ((s4_qe_reg[i] == 9'(lhce_pkg::OUT_MAX - 1))
                    && (s4_p_reg[i] >= s4_lim_reg[i])))
            begin
                ch_c[i] = 8'(lhce_pkg::OUT_MAX);
            end
            else
            begin
                ch_c[i] = s4_qe_reg[i][7:0] + ((s4_p_reg[i] >= s4_lim_reg[i]) ? 8'd1 : 8'd0);
            end
            if (9'((17'(s5_ch_reg[i]) * 17'(gain_c[i])) >> 8) > 9'(lhce_pkg::OUT_MAX))
            begin
                bal_c[i] = 8'(lhce_pkg::OUT_MAX);
            end
            else
            begin
                bal_c[i] = 8'((17'(s5_ch_reg[i]) * 17'(gain_c[i])) >> 8);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_level_reg <= q_job.level;
            s0_sat_reg   <= q_job.sat;
            s0_dark_reg  <= q_job.dark;
            s1_level_reg <= s0_level_reg;
            s1_dark_reg  <= s0_dark_reg;
            s2_dark_reg  <= s1_dark_reg;
            s3_dark_reg  <= s2_dark_reg;
            s4_dark_reg  <= s3_dark_reg;
            s5_dark_reg  <= s4_dark_reg;
            for (int i = 0; i < NLANE; i++)
            begin
                s0_g_reg[i]     <= g_c[i];
                s1_inner_reg[i] <= inner_c[i];
                s2_prod_reg[i]  <= prod_c[i];
                s3_qe_reg[i]    <= qe_c[i];
                s3_prod_reg[i]  <= s2_prod_reg[i];
                s4_p_reg[i]     <= p_c[i];
                s4_lim_reg[i]   <= lim_c[i];
                s4_qe_reg[i]    <= s3_qe_reg[i];
                s5_ch_reg[i]    <= ch_c[i];
            end
            res_reg.red   <= s5_dark_reg ? 8'd0 : bal_c[0];
            res_reg.green <= s5_dark_reg ? 8'd0 : bal_c[1];
            res_reg.blue  <= s5_dark_reg ? 8'd0 : bal_c[2];
            res_reg.lit   <= !s5_dark_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg       <= {vld_reg[NSTG-2:0], !qstat.empty};
            res_valid_reg <= vld_reg[NSTG-1];
        end
    end

    assign empty    = !res_valid_reg;
    assign out_data = res_reg;

endmodule

`default_nettype wire

// ----- sv/lamp_hsv_color_engine.sv -----
// lamp hsv color engine: an accepted write passes the job queue and the color pipeline to the result register
// throughput one write per cycle while the job queue is not full; the six-stage color pipeline stalls as a whole
// while the result register holds an untaken transaction
// writes to foreign endpoints are taken and give no result
// rst_n is asynchronous: clears queue, pipeline valids and lamp state, loads register defaults
`default_nettype none

module lamp_hsv_color_engine (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire lhce_pkg::in_item_t                  in_data,
    output logic                                     empty,
    input  wire logic                                pop,
    output lhce_pkg::out_item_t                      out_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lhce_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lhce_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [15:0] own_endpoint_reg;
    logic [8:0]  gain_red_reg;
    logic [8:0]  gain_green_reg;
    logic [8:0]  gain_blue_reg;

    lhce_pkg::qstat_t qstat;
    lhce_pkg::job_t   wr_job;
    lhce_pkg::job_t   rd_job;
    lhce_pkg::gains_t gains;
    logic             q_wr;
    logic             q_rd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_endpoint_reg <= lhce_pkg::OWN_EP_RST;
            gain_red_reg     <= lhce_pkg::GAIN_RED_RST;
            gain_green_reg   <= lhce_pkg::GAIN_GREEN_RST;
            gain_blue_reg    <= lhce_pkg::GAIN_BLUE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lhce_pkg::CFG_OWN_EP:     own_endpoint_reg <= cfg_data;
                lhce_pkg::CFG_GAIN_RED:   gain_red_reg     <= cfg_data[8:0];
                lhce_pkg::CFG_GAIN_GREEN: gain_green_reg   <= cfg_data[8:0];
                lhce_pkg::CFG_GAIN_BLUE:  gain_blue_reg    <= cfg_data[8:0];
                default:                  ;
            endcase
        end
    end

    assign gains.red   = gain_red_reg;
    assign gains.green = gain_green_reg;
    assign gains.blue  = gain_blue_reg;

    lhce_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_data      (in_data),
        .own_endpoint (own_endpoint_reg),
        .qstat        (qstat),
        .q_wr         (q_wr),
        .q_job        (wr_job)
    );

    lhce_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_job (wr_job),
        .rd     (q_rd),
        .rd_job (rd_job),
        .stat   (qstat)
    );

    lhce_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .q_job    (rd_job),
        .q_rd     (q_rd),
        .gains    (gains),
        .pop      (pop),
        .empty    (empty),
        .out_data (out_data)
    );

`ifndef SYNTHESIS
    // a dark lamp always shows black
    a_dark_black: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_data.lit) |-> (out_data.red == 8'd0 && out_data.green == 8'd0
                                       && out_data.blue == 8'd0))
        else $error("dark result carries color");

    // job queue never holds more than its depth
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= lhce_pkg::QCNT_W'(lhce_pkg::QDEPTH))
        else $error("job queue overflow");

    // a write to a foreign endpoint issues no job
    a_foreign: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && in_data.endpoint != own_endpoint_reg) |-> !q_wr)
        else $error("foreign endpoint write issued a job");

    // queue count rises by one on a write transaction without a read transaction
    a_q_count: assert property (@(posedge clk) disable iff (!rst_n)
        (q_wr && !qstat.full && !(q_rd && !qstat.empty))
            |=> qstat.count == $past(qstat.count) + 1'b1)
        else $error("job queue count mismatch");
`endif

endmodule

`default_nettype wire
